>>> sv/assert_macros.svh
// ============================================================================
// Assertion macros
// Shared concurrent assertion forms, clocked and disabled during reset.
// ============================================================================
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check that the consequent holds in the same cycle as the antecedent
`define ASSERT_IMPLY(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Check that the consequent holds in the cycle after the antecedent
`define ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> sv/e2cal_pkg.sv
// ============================================================================
// e2cal_pkg
// Constants, reciprocal multipliers and tables for the epoch to calendar
// conversion pipeline.
// ============================================================================
package e2cal_pkg;

    // Port and datapath widths
    localparam int SECONDS_WIDTH = 48;
    localparam int IN_DATA_W     = 48;
    localparam int OUT_DATA_W    = 64;
    localparam int U_W           = 49;
    localparam int STAGES        = 13;

    // Calendar constants
    localparam logic [63:0] ERA_BIAS      = 64'd11150;
    localparam logic [63:0] ERA_DAYS_64   = 64'd146097;
    localparam logic [63:0] DAY_SEC_64    = 64'd86400;
    localparam logic [31:0] ERA_DAYS      = 32'd146097;
    localparam logic [31:0] EPOCH_SHIFT   = 32'd719468;
    localparam logic [17:0] CENT_DAYS     = 18'd36524;
    localparam logic [17:0] LAST_ERA_DAY  = 18'd146096;
    localparam logic [8:0]  YEAR_DAYS     = 9'd365;
    localparam logic [8:0]  YEARS_PER_ERA = 9'd400;
    localparam logic [8:0]  CENT_YEARS    = 9'd100;
    localparam logic [9:0]  DIV_675       = 10'd675;
    localparam logic [11:0] HOUR_SECONDS  = 12'd3600;
    localparam logic [5:0]  MIN_SECONDS   = 6'd60;
    localparam logic [2:0]  WEEK_DAYS     = 3'd7;
    localparam logic [2:0]  WDAY_SHIFT    = 3'd3;
    localparam logic [3:0]  JAN_MP        = 4'd10;
    localparam logic [3:0]  MAR_MONTH     = 4'd2;
    localparam logic [8:0]  MAR1_YDAY     = 9'd59;
    localparam logic [8:0]  JAN1_DOY      = 9'd306;

    // Bias that keeps all seconds positive: a whole number of eras in seconds
    localparam logic [U_W-1:0] SEC_OFFSET =
        U_W'(ERA_BIAS * ERA_DAYS_64 * DAY_SEC_64);
    // Year correction for the era bias and the 1900 origin
    localparam logic [23:0] YEAR_BIAS = 24'(64'd400 * ERA_BIAS + 64'd1900);

    // Reciprocal shifts and multipliers: q = (x * M) >> S, exact for x < 2^n
    localparam int S675A = 31;
    localparam int S675B = 41;
    localparam int S_ERA = 50;
    localparam int S3600 = 29;
    localparam int S60   = 18;
    localparam int S1460 = 29;
    localparam int S7    = 21;
    localparam int S365  = 27;
    localparam int S153  = 19;

    localparam logic [21:0] M675A = 22'(((64'd1 << S675A) + 64'd674) / 64'd675);
    localparam logic [31:0] M675B = 32'(((64'd1 << S675B) + 64'd674) / 64'd675);
    localparam logic [32:0] M_ERA = 33'(((64'd1 << S_ERA) + 64'd146096) / 64'd146097);
    localparam logic [17:0] M3600 = 18'(((64'd1 << S3600) + 64'd3599) / 64'd3600);
    localparam logic [12:0] M60   = 13'(((64'd1 << S60) + 64'd59) / 64'd60);
    localparam logic [18:0] M1460 = 19'(((64'd1 << S1460) + 64'd1459) / 64'd1460);
    localparam logic [18:0] M7    = 19'(((64'd1 << S7) + 64'd6) / 64'd7);
    localparam logic [18:0] M365  = 19'(((64'd1 << S365) + 64'd364) / 64'd365);
    localparam logic [11:0] M153  = 12'(((64'd1 << S153) + 64'd152) / 64'd153);

    // Time of day carried down the pipe
    typedef struct packed {
        logic [4:0] hour;
        logic [5:0] minute;
        logic [5:0] second;
    } t_tod;

    // Day of the March-based year on which month index mp starts
    function automatic logic [8:0] mp_start(input logic [3:0] mp);
        logic [8:0] v;
        case (mp)
            4'd0:    v = 9'd0;
            4'd1:    v = 9'd31;
            4'd2:    v = 9'd61;
            4'd3:    v = 9'd92;
            4'd4:    v = 9'd122;
            4'd5:    v = 9'd153;
            4'd6:    v = 9'd184;
            4'd7:    v = 9'd214;
            4'd8:    v = 9'd245;
            4'd9:    v = 9'd275;
            4'd10:   v = 9'd306;
            4'd11:   v = 9'd337;
            default: v = 9'd0;
        endcase
        return v;
    endfunction

endpackage

>>> sv/epoch_seconds_to_calendar.sv
// Throughput: one word per cycle while m_tready does not stall the output;
// thirteen register stages, each at most two constant multiplies deep; the
// longest path is the month index, a multiply, an add and a multiply.
// Stages advance independently, so empty stages fill while the output stalls.
// Reset (i_rst_n low, synchronous) clears the stage valid bits only.
// ============================================================================
// epoch_seconds_to_calendar
// Converts signed seconds since 1970-01-01 UTC to broken-down Gregorian time.
// ============================================================================
`include "assert_macros.svh"

module epoch_seconds_to_calendar #(
    parameter int SECONDS_WIDTH = e2cal_pkg::SECONDS_WIDTH
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             s_tvalid,
    output logic                             s_tready,
    // epoch_seconds[47:0]
    input  logic [e2cal_pkg::IN_DATA_W-1:0]  s_tdata,
    output logic                             m_tvalid,
    input  logic                             m_tready,
    // second[5:0], minute[11:6], hour[16:12], day_of_month[21:17],
    // month[25:22], years_since_1900[49:26], weekday[52:50],
    // year_day[61:53], zero pad[63:62]
    output logic [e2cal_pkg::OUT_DATA_W-1:0] m_tdata
);

    localparam int NS  = e2cal_pkg::STAGES;
    localparam int UW  = e2cal_pkg::U_W;
    localparam int EXT = UW - SECONDS_WIDTH;

    // Stage control
    logic [NS:1]   r_vld;
    logic [NS+1:1] adv;

    // Stage registers
    logic [UW-1:0] r_s1_u;
    logic [11:0]   r_s2_qhi, r_s3_qhi, r_s4_qhi;
    logic [20:0]   r_s2_vhi, r_s2_vlo, r_s4_qlo;
    logic [6:0]    r_s2_low7, r_s3_low7, r_s4_low7;
    logic [30:0]   r_s3_w, r_s4_w;
    logic [31:0]   r_s5_z, r_s6_z;
    logic [16:0]   r_s5_sod, r_s6_sod;
    logic [14:0]   r_s6_era;
    logic [4:0]    r_s6_hour, r_s7_hour, r_s8_hour;
    logic [17:0]   r_s7_doe, r_s8_doe, r_s9_doe, r_s10_doe, r_s9_x;
    logic [23:0]   r_s7_yb, r_s8_yb, r_s9_yb, r_s10_yb, r_s11_yb, r_s12_yb;
    logic [11:0]   r_s7_rem, r_s8_rem;
    logic [6:0]    r_s8_t1;
    logic [5:0]    r_s8_min;
    logic [14:0]   r_s9_wq;
    logic [8:0]    r_s10_yoe, r_s11_yoe, r_s12_yoe, r_s11_doy, r_s12_doy;
    logic [2:0]    r_s10_wd, r_s11_wd, r_s12_wd;
    logic          r_s11_leap, r_s12_leap;
    logic [3:0]    r_s12_mp;
    e2cal_pkg::t_tod r_s9_tod, r_s10_tod, r_s11_tod, r_s12_tod, r_s13_tod;
    logic [4:0]    r_s13_dom;
    logic [3:0]    r_s13_month;
    logic [23:0]   r_s13_ys;
    logic [2:0]    r_s13_wday;
    logic [8:0]    r_s13_yday;

    // Next values
    logic [UW-1:0] n_s1_u;
    logic [42:0]   n_s2_p;
    logic [11:0]   n_s2_qhi;
    logic [9:0]    n_s3_rhi, n_s5_rlo;
    logic [30:0]   n_s3_w;
    logic [62:0]   n_s4_p;
    logic [20:0]   n_s4_qlo;
    logic [32:0]   n_s5_days;
    logic [31:0]   n_s5_z;
    logic [16:0]   n_s5_sod;
    logic [64:0]   n_s6_pe;
    logic [14:0]   n_s6_era;
    logic [34:0]   n_s6_ph;
    logic [4:0]    n_s6_hour;
    logic [17:0]   n_s7_doe;
    logic [23:0]   n_s7_yb;
    logic [11:0]   n_s7_rem;
    logic [36:0]   n_s8_pt;
    logic [6:0]    n_s8_t1;
    logic [24:0]   n_s8_pm;
    logic [5:0]    n_s8_min;
    logic [2:0]    n_s9_t2;
    logic          n_s9_t3;
    logic [17:0]   n_s9_x;
    logic [36:0]   n_s9_pw;
    logic [14:0]   n_s9_wq;
    e2cal_pkg::t_tod n_s9_tod;
    logic [36:0]   n_s10_py;
    logic [8:0]    n_s10_yoe;
    logic [2:0]    n_s10_wd;
    logic [1:0]    n_s11_c100;
    logic [8:0]    n_s11_doy;
    logic          n_s11_leap;
    logic [10:0]   n_s12_t;
    logic [22:0]   n_s12_p;
    logic [3:0]    n_s12_mp;
    logic          n_s13_janfeb;
    logic [4:0]    n_s13_dom;
    logic [3:0]    n_s13_month;
    logic [23:0]   n_s13_ys;
    logic [8:0]    n_s13_yday;

    // Range flags for the checks
    logic          tod_ok, date_ok;

    // Let each stage advance when it is empty or its successor advances
    always_comb begin
        adv[NS+1] = m_tready;
        for (int k = NS; k >= 1; k--) begin
            adv[k] = !r_vld[k] || adv[k+1];
        end
    end

    assign s_tready = adv[1];
    assign m_tvalid = r_vld[NS];

    // Move valid bits with the data
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            if (adv[1]) begin
                r_vld[1] <= s_tvalid;
            end
            for (int k = 2; k <= NS; k++) begin
                if (adv[k]) begin
                    r_vld[k] <= r_vld[k-1];
                end
            end
        end
    end

    // Datapath next values
    always_comb begin
        // Sign-extend and bias to a positive count of seconds
        n_s1_u = {{EXT{s_tdata[SECONDS_WIDTH-1]}}, s_tdata[SECONDS_WIDTH-1:0]}
                 + e2cal_pkg::SEC_OFFSET;

        // Days = (u >> 7) / 675, high chunk first
        n_s2_p   = 43'(r_s1_u[UW-1:28]) * 43'(e2cal_pkg::M675A);
        n_s2_qhi = 12'(n_s2_p >> e2cal_pkg::S675A);
        n_s3_rhi = 10'(r_s2_vhi - 21'(r_s2_qhi) * 21'(e2cal_pkg::DIV_675));
        n_s3_w   = {n_s3_rhi, r_s2_vlo};
        n_s4_p   = 63'(r_s3_w) * 63'(e2cal_pkg::M675B);
        n_s4_qlo = 21'(n_s4_p >> e2cal_pkg::S675B);
        n_s5_rlo = 10'(r_s4_w - 31'(r_s4_qlo) * 31'(e2cal_pkg::DIV_675));
        n_s5_days = {r_s4_qhi, r_s4_qlo};
        n_s5_z   = n_s5_days[31:0] + e2cal_pkg::EPOCH_SHIFT;
        n_s5_sod = {n_s5_rlo, r_s4_low7};

        // Era and hour
        n_s6_pe   = 65'(r_s5_z) * 65'(e2cal_pkg::M_ERA);
        n_s6_era  = 15'(n_s6_pe >> e2cal_pkg::S_ERA);
        n_s6_ph   = 35'(r_s5_sod) * 35'(e2cal_pkg::M3600);
        n_s6_hour = 5'(n_s6_ph >> e2cal_pkg::S3600);

        // Day of era, biased year base, seconds within the hour
        n_s7_doe = 18'(r_s6_z - 32'(r_s6_era) * e2cal_pkg::ERA_DAYS);
        n_s7_yb  = 24'(24'(r_s6_era) * 24'(e2cal_pkg::YEARS_PER_ERA)
                       - e2cal_pkg::YEAR_BIAS);
        n_s7_rem = 12'(r_s6_sod - 17'(r_s6_hour) * 17'(e2cal_pkg::HOUR_SECONDS));

        // Four-year cycles in the era, minute
        n_s8_pt  = 37'(r_s7_doe) * 37'(e2cal_pkg::M1460);
        n_s8_t1  = 7'(n_s8_pt >> e2cal_pkg::S1460);
        n_s8_pm  = 25'(r_s7_rem) * 25'(e2cal_pkg::M60);
        n_s8_min = 6'(n_s8_pm >> e2cal_pkg::S60);

        // Leap-corrected day count, week quotient, second
        n_s9_t2 = 3'(r_s8_doe >= e2cal_pkg::CENT_DAYS)
                + 3'(r_s8_doe >= 18'(2 * e2cal_pkg::CENT_DAYS))
                + 3'(r_s8_doe >= 18'(3 * e2cal_pkg::CENT_DAYS))
                + 3'(r_s8_doe >= e2cal_pkg::LAST_ERA_DAY);
        n_s9_t3 = (r_s8_doe == e2cal_pkg::LAST_ERA_DAY);
        n_s9_x  = r_s8_doe - 18'(r_s8_t1) + 18'(n_s9_t2) - 18'(n_s9_t3);
        n_s9_pw = 37'(18'(r_s8_doe + 18'(e2cal_pkg::WDAY_SHIFT)))
                  * 37'(e2cal_pkg::M7);
        n_s9_wq = 15'(n_s9_pw >> e2cal_pkg::S7);
        n_s9_tod.hour   = r_s8_hour;
        n_s9_tod.minute = r_s8_min;
        n_s9_tod.second = 6'(r_s8_rem - 12'(r_s8_min) * 12'(e2cal_pkg::MIN_SECONDS));

        // Year of era, weekday
        n_s10_py  = 37'(r_s9_x) * 37'(e2cal_pkg::M365);
        n_s10_yoe = 9'(n_s10_py >> e2cal_pkg::S365);
        n_s10_wd  = 3'(18'(r_s9_doe + 18'(e2cal_pkg::WDAY_SHIFT))
                       - 18'(r_s9_wq) * 18'(e2cal_pkg::WEEK_DAYS));

        // Day of the March-based year, leap flag of that year
        n_s11_c100 = 2'(r_s10_yoe >= e2cal_pkg::CENT_YEARS)
                   + 2'(r_s10_yoe >= 9'(2 * e2cal_pkg::CENT_YEARS))
                   + 2'(r_s10_yoe >= 9'(3 * e2cal_pkg::CENT_YEARS));
        n_s11_doy  = 9'(r_s10_doe - (18'(r_s10_yoe) * 18'(e2cal_pkg::YEAR_DAYS)
                       + 18'(r_s10_yoe[8:2]) - 18'(n_s11_c100)));
        n_s11_leap = (r_s10_yoe[1:0] == 2'b00)
                  && (r_s10_yoe != e2cal_pkg::CENT_YEARS)
                  && (r_s10_yoe != 9'(2 * e2cal_pkg::CENT_YEARS))
                  && (r_s10_yoe != 9'(3 * e2cal_pkg::CENT_YEARS));

        // March-based month index
        n_s12_t  = 11'(11'(r_s11_doy) * 11'd5 + 11'd2);
        n_s12_p  = 23'(n_s12_t) * 23'(e2cal_pkg::M153);
        n_s12_mp = 4'(n_s12_p >> e2cal_pkg::S153);

        // Final calendar fields
        n_s13_janfeb = (r_s12_mp >= e2cal_pkg::JAN_MP);
        n_s13_dom    = 5'(r_s12_doy - e2cal_pkg::mp_start(r_s12_mp) + 9'd1);
        n_s13_month  = n_s13_janfeb ? 4'(r_s12_mp - e2cal_pkg::JAN_MP)
                                    : 4'(r_s12_mp + e2cal_pkg::MAR_MONTH);
        n_s13_ys     = r_s12_yb + 24'(r_s12_yoe) + 24'(n_s13_janfeb);
        n_s13_yday   = n_s13_janfeb ? 9'(r_s12_doy - e2cal_pkg::JAN1_DOY)
                                    : 9'(r_s12_doy + e2cal_pkg::MAR1_YDAY
                                         + 9'(r_s12_leap));
    end

    // Load each stage when it advances
    always_ff @(posedge i_clk) begin
        if (adv[1]) begin
            r_s1_u <= n_s1_u;
        end
        if (adv[2]) begin
            r_s2_qhi  <= n_s2_qhi;
            r_s2_vhi  <= r_s1_u[UW-1:28];
            r_s2_vlo  <= r_s1_u[27:7];
            r_s2_low7 <= r_s1_u[6:0];
        end
        if (adv[3]) begin
            r_s3_w    <= n_s3_w;
            r_s3_qhi  <= r_s2_qhi;
            r_s3_low7 <= r_s2_low7;
        end
        if (adv[4]) begin
            r_s4_qlo  <= n_s4_qlo;
            r_s4_w    <= r_s3_w;
            r_s4_qhi  <= r_s3_qhi;
            r_s4_low7 <= r_s3_low7;
        end
        if (adv[5]) begin
            r_s5_z   <= n_s5_z;
            r_s5_sod <= n_s5_sod;
        end
        if (adv[6]) begin
            r_s6_era  <= n_s6_era;
            r_s6_z    <= r_s5_z;
            r_s6_hour <= n_s6_hour;
            r_s6_sod  <= r_s5_sod;
        end
        if (adv[7]) begin
            r_s7_doe  <= n_s7_doe;
            r_s7_yb   <= n_s7_yb;
            r_s7_rem  <= n_s7_rem;
            r_s7_hour <= r_s6_hour;
        end
        if (adv[8]) begin
            r_s8_t1   <= n_s8_t1;
            r_s8_doe  <= r_s7_doe;
            r_s8_yb   <= r_s7_yb;
            r_s8_min  <= n_s8_min;
            r_s8_rem  <= r_s7_rem;
            r_s8_hour <= r_s7_hour;
        end
        if (adv[9]) begin
            r_s9_x   <= n_s9_x;
            r_s9_wq  <= n_s9_wq;
            r_s9_doe <= r_s8_doe;
            r_s9_yb  <= r_s8_yb;
            r_s9_tod <= n_s9_tod;
        end
        if (adv[10]) begin
            r_s10_yoe <= n_s10_yoe;
            r_s10_wd  <= n_s10_wd;
            r_s10_doe <= r_s9_doe;
            r_s10_yb  <= r_s9_yb;
            r_s10_tod <= r_s9_tod;
        end
        if (adv[11]) begin
            r_s11_doy  <= n_s11_doy;
            r_s11_leap <= n_s11_leap;
            r_s11_yoe  <= r_s10_yoe;
            r_s11_wd   <= r_s10_wd;
            r_s11_yb   <= r_s10_yb;
            r_s11_tod  <= r_s10_tod;
        end
        if (adv[12]) begin
            r_s12_mp   <= n_s12_mp;
            r_s12_doy  <= r_s11_doy;
            r_s12_leap <= r_s11_leap;
            r_s12_yoe  <= r_s11_yoe;
            r_s12_wd   <= r_s11_wd;
            r_s12_yb   <= r_s11_yb;
            r_s12_tod  <= r_s11_tod;
        end
        if (adv[13]) begin
            r_s13_dom   <= n_s13_dom;
            r_s13_month <= n_s13_month;
            r_s13_ys    <= n_s13_ys;
            r_s13_wday  <= r_s12_wd;
            r_s13_yday  <= n_s13_yday;
            r_s13_tod   <= r_s12_tod;
        end
    end

    // Pack the result word
    assign m_tdata = {2'b00, r_s13_yday, r_s13_wday, r_s13_ys, r_s13_month, r_s13_dom,
                      r_s13_tod.hour, r_s13_tod.minute, r_s13_tod.second};

    // Range of the output fields
    assign tod_ok  = (r_s13_tod.second < 6'd60) && (r_s13_tod.minute < 6'd60)
                  && (r_s13_tod.hour < 5'd24);
    assign date_ok = (r_s13_dom != 5'd0) && (r_s13_month < 4'd12)
                  && (r_s13_wday < 3'd7) && (r_s13_yday <= 9'd365);

    // Checks
    `ASSERT_IMPLY(a_tod_range, i_clk, i_rst_n, m_tvalid, tod_ok, "time of day out of range")
    `ASSERT_IMPLY(a_date_range, i_clk, i_rst_n, m_tvalid, date_ok, "calendar field out of range")
    `ASSERT_NEXT(a_entry, i_clk, i_rst_n, s_tvalid && s_tready, r_vld[1], "word lost at entry")

endmodule

>>> test/epoch_seconds_to_calendar_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// epoch_seconds_to_calendar_tb
// Drives signed epoch seconds into the converter and checks every result word
// against a behavioral calendar model: directed dates, full-range and
// near-epoch random times, day and era edges, bursty input and output stalls.
// ----------------------------------------------------------------------------
module epoch_seconds_to_calendar_tb;

    localparam int SEC_W         = e2cal_pkg::SECONDS_WIDTH;
    localparam int IN_W          = e2cal_pkg::IN_DATA_W;
    localparam int OUT_W         = e2cal_pkg::OUT_DATA_W;
    localparam int IDLE_LIMIT    = 4000;
    localparam int TAIL_CYCLES   = 3 * e2cal_pkg::STAGES;

    // Broken-down time, packed as on m_tdata from bit 0 up
    typedef struct packed {
        logic [8:0]  year_day;
        logic [2:0]  weekday;
        logic [23:0] years_since_1900;
        logic [3:0]  month;
        logic [4:0]  day_of_month;
        logic [4:0]  hour;
        logic [5:0]  minute;
        logic [5:0]  second;
    } t_civil;

    logic             i_clk = 1'b0;
    logic             i_rst_n = 1'b0;
    logic             s_tvalid = 1'b0;
    logic             s_tready;
    logic [IN_W-1:0]  s_tdata = '0;     // epoch_seconds[47:0]
    logic             m_tvalid;
    logic             m_tready = 1'b0;
    logic [OUT_W-1:0] m_tdata;          // second, minute, hour, day_of_month,
                                        // month, years_since_1900, weekday,
                                        // year_day, zero pad

    t_civil pending_dates[$];
    int     mismatch_count = 0;
    int     words_sent = 0;
    int     dates_checked = 0;
    int     negative_sent = 0;
    int     idle_cycles = 0;
    int     burst_left = 0;
    int     ready_mode = 0;
    int     ready_stretch = 0;

    epoch_seconds_to_calendar u_top (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    // Free-running clock
    initial begin
        forever #5 i_clk = ~i_clk;
    end

    // Quotient rounded toward minus infinity, divisor positive
    function automatic longint floor_quot(longint num, longint den);
        longint q;
        q = num / den;
        if ((num % den) != 0 && num < 0) begin
            q = q - 1;
        end
        return q;
    endfunction

    // Convert epoch seconds to Gregorian fields with March-based eras
    function automatic t_civil civil_time(logic [IN_W-1:0] raw);
        longint secs, days, sod, z, era, doe, yoe, doy, mp, dom, mon, year, yday, wd;
        bit     leap;
        t_civil c;
        secs = longint'(raw);
        secs = (secs <<< (64 - SEC_W)) >>> (64 - SEC_W);
        days = floor_quot(secs, 86400);
        sod  = secs - days * 86400;
        z    = days + 719468;
        era  = floor_quot(z, 146097);
        doe  = z - era * 146097;
        yoe  = (doe - doe / 1460 + doe / 36524 - doe / 146096) / 365;
        doy  = doe - (365 * yoe + yoe / 4 - yoe / 100);
        mp   = (5 * doy + 2) / 153;
        dom  = doy - (153 * mp + 2) / 5 + 1;
        mon  = (mp < 10) ? mp + 3 : mp - 9;
        year = yoe + era * 400 + ((mon <= 2) ? 1 : 0);
        leap = ((year % 4) == 0 && (year % 100) != 0) || ((year % 400) == 0);
        // January and February close the March-based year; March 1 is day 59 or 60
        if (mon <= 2) begin
            yday = doy - 306;
        end else begin
            yday = doy + 59 + (leap ? 1 : 0);
        end
        wd = days - floor_quot(days, 7) * 7;
        wd = (wd + 4) % 7;
        c.second           = 6'(sod % 60);
        c.minute           = 6'((sod / 60) % 60);
        c.hour             = 5'(sod / 3600);
        c.day_of_month     = 5'(dom);
        c.month            = 4'(mon - 1);
        c.years_since_1900 = 24'(year - 1900);
        c.weekday          = 3'(wd);
        c.year_day         = 9'(yday);
        return c;
    endfunction

    // Uniform signed value in [-span, span] as an input word
    function automatic logic [IN_W-1:0] rand_span(longint span);
        bit [63:0] r;
        r = {$urandom, $urandom};
        return IN_W'(longint'(r % 64'(2 * span + 1)) - span);
    endfunction

    // Flag one field mismatch
    task automatic flag_field(string name, longint want, longint got);
        if (want != got) begin
            mismatch_count++;
            $error("%s: expected %0d, got %0d", name, want, got);
        end
    endtask

    // Queue a prediction per accepted word, check each result word
    always @(posedge i_clk) begin
        t_civil want, got;
        if (i_rst_n) begin
            if (s_tvalid && s_tready) begin
                pending_dates.push_back(civil_time(s_tdata));
            end
            if (m_tvalid && m_tready) begin
                if (pending_dates.size() == 0) begin
                    mismatch_count++;
                    $error("result word with no pending conversion: %h", m_tdata);
                end else begin
                    want = pending_dates.pop_front();
                    got  = t_civil'(m_tdata[61:0]);
                    dates_checked++;
                    flag_field("second", want.second, got.second);
                    flag_field("minute", want.minute, got.minute);
                    flag_field("hour", want.hour, got.hour);
                    flag_field("day_of_month", want.day_of_month, got.day_of_month);
                    flag_field("month", want.month, got.month);
                    flag_field("years_since_1900", longint'($signed(want.years_since_1900)),
                               longint'($signed(got.years_since_1900)));
                    flag_field("weekday", want.weekday, got.weekday);
                    flag_field("year_day", want.year_day, got.year_day);
                    flag_field("zero pad", 0, m_tdata[63:62]);
                end
            end
        end
    end

    // Stall the output on a shifting pattern: open, coin-flip, or mostly closed
    always @(posedge i_clk) begin
        if (ready_stretch == 0) begin
            ready_mode    = $urandom_range(0, 2);
            ready_stretch = $urandom_range(20, 200);
        end else begin
            ready_stretch = ready_stretch - 1;
        end
        case (ready_mode)
            0: begin
                m_tready <= 1'b1;
            end
            1: begin
                m_tready <= 1'($urandom_range(0, 1));
            end
            default: begin
                m_tready <= ($urandom_range(0, 7) == 0);
            end
        endcase
    end

    // End the run when nothing moves for too long
    always @(posedge i_clk) begin
        if (!i_rst_n || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= IDLE_LIMIT) begin
            $display("tb: failure");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    // Offer one word in bursts with random gaps, return once it is taken
    task automatic send_seconds(logic [IN_W-1:0] raw);
        int gap;
        gap = 0;
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 40);
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
        end
        burst_left--;
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= raw;
        do @(posedge i_clk); while (!s_tready);
        words_sent++;
        if (raw[SEC_W-1]) begin
            negative_sent++;
        end
    endtask

    // Hold the input until every pending conversion has come back
    task automatic wait_drained();
        s_tvalid   <= 1'b0;
        burst_left = 0;
        do @(posedge i_clk); while (pending_dates.size() != 0);
    endtask

    // Epoch, day and leap edges, 32-bit wrap points, era starts, range ends
    task automatic test_directed_dates();
        longint marks[$] = '{
            64'sd0, -64'sd1, 64'sd1, 64'sd86399, 64'sd86400, -64'sd86400, -64'sd86401,
            64'sd2147483647, 64'sd2147483648, -64'sd2147483649,
            64'sd951782400, 64'sd951868800, 64'sd978307199,
            -64'sd2203891200, -64'sd2198793600, 64'sd4107542399, 64'sd4107542400,
            -64'sd62162035200, -64'sd62162035201, 64'sd1735603200,
            64'sd140737488355327, -64'sd140737488355328,
            64'sh555555555555, 64'shAAAAAAAAAAAA
        };
        foreach (marks[i]) begin
            send_seconds(IN_W'(marks[i]));
        end
    endtask

    // Any bit pattern of the input word
    task automatic test_full_range(int count);
        for (int i = 0; i < count; i++) begin
            send_seconds(IN_W'({$urandom, $urandom}));
        end
    endtask

    // Times within tens of thousands of years of the epoch
    task automatic test_civil_range(int count);
        for (int i = 0; i < count; i++) begin
            if ($urandom_range(0, 1) == 0) begin
                send_seconds(rand_span(64'sd1 <<< 39));
            end else begin
                send_seconds(rand_span(64'sd1 <<< 32));
            end
        end
    endtask

    // Land on midnight, the second after it, last second and noon of random days and days near era starts
    task automatic test_day_edges(int count);
        longint day_no, offs;
        for (int i = 0; i < count; i++) begin
            if ($urandom_range(0, 1) == 0) begin
                day_no = longint'($signed($urandom_range(0, 6000000))) - 3000000;
            end else begin
                day_no = (longint'($urandom_range(0, 80)) - 40) * 146097 - 719468
                         + longint'($urandom_range(0, 800)) - 400;
            end
            case ($urandom_range(0, 4))
                0:       offs = 0;
                1:       offs = 1;
                2:       offs = -1;
                3:       offs = 43200;
                default: offs = 86399;
            endcase
            send_seconds(IN_W'(day_no * 86400 + offs));
        end
    endtask

    // Short runs separated by full drains of the pipeline
    task automatic test_drain_pause(int count);
        int run_len;
        int sent;
        sent = 0;
        while (sent < count) begin
            run_len = ($urandom_range(0, 3) == 0) ? 1 : $urandom_range(2, 30);
            for (int i = 0; i < run_len; i++) begin
                send_seconds(rand_span(64'sd1 <<< 35));
            end
            sent += run_len;
            wait_drained();
        end
    endtask

    // Sequence the tests and report
    initial begin
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_directed_dates();
        test_full_range(350);
        test_civil_range(450);
        test_day_edges(300);
        test_drain_pause(200);

        wait_drained();
        repeat (TAIL_CYCLES) @(posedge i_clk);

        $display("covered %0d words (%0d negative), %0d results checked:", words_sent,
                 negative_sent, dates_checked);
        $display("  directed dates, full-range, near-epoch, day/era edges, drain pauses");
        if (mismatch_count == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

endmodule
